/* hdl/salru_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// salru_pkg
// Shared types and constants for the set-associative LRU cache tracker.
// ----------------------------------------------------------------------------
package salru_pkg;

  localparam int MAX_SETS  = 256;
  localparam int MAX_WAYS  = 8;
  localparam int SET_W     = $clog2(MAX_SETS);
  localparam int WAY_W     = $clog2(MAX_WAYS);
  localparam int TAG_W     = 64;
  localparam int AGE_W     = 32;
  localparam int CNT_W     = 32;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 6;

  // operation codes
  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_STORE  = 2'd1;
  localparam logic [1:0] OP_MODIFY = 2'd2;
  localparam logic [1:0] OP_NONE   = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SET_BITS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WAYS_USED  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_BITS = 2'd2;

  typedef struct packed {
    logic [1:0]  op;
    logic [63:0] addr;
  } in_item_t;

  typedef struct packed {
    logic             hit;
    logic             miss;
    logic             eviction;
    logic             last;
    logic [CNT_W-1:0] hits_total;
    logic [CNT_W-1:0] misses_total;
    logic [CNT_W-1:0] evictions_total;
  } out_item_t;

  // one set as stored in the memory
  typedef struct packed {
    logic [MAX_WAYS-1:0]             valid;
    logic [MAX_WAYS-1:0][TAG_W-1:0]  tag;
    logic [MAX_WAYS-1:0][AGE_W-1:0]  age;
  } set_row_t;

  typedef struct packed {
    logic hit;
    logic miss;
    logic eviction;
  } lookup_res_t;

endpackage
`default_nettype wire

/* hdl/set_assoc_lru_cache_tracker_top.sv */
`default_nettype none
// Order: an accepted item's set row is registered, then looked up when the
//   output register is free; a modify's second lookup follows its first.
// Throughput: one load or store item per cycle while results are taken; a
//   modify holds off input for its second lookup; a same-set row is forwarded
//   from the write-back. Reset: synchronous; counters, config and a per-set
//   row valid bit clear at once, so no clearing pass over the set memory is needed.
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_tracker_top
// Tracks a set-associative cache with age-counter LRU replacement and
// reports hit, miss, eviction and saturating running totals per lookup.
// ----------------------------------------------------------------------------
module set_assoc_lru_cache_tracker_top (
  input  var logic                              clk,
  input  var logic                              rst_n,
  input  var logic                              in_valid,
  output logic                                  in_ready,
  input  var salru_pkg::in_item_t               in_data,
  output logic                                  out_valid,
  input  var logic                              out_ready,
  output salru_pkg::out_item_t                  out_data,
  input  var logic                              cfg_we,
  input  var logic [salru_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  var logic [salru_pkg::CFG_DAT_W-1:0]   cfg_wdata
);
  import salru_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_LOOK = 1'b1;

  // configuration
  logic [3:0] set_bits_r;
  logic [3:0] ways_r;
  logic [5:0] block_bits_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      set_bits_r   <= '0;
      ways_r       <= 4'd1;
      block_bits_r <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_SET_BITS:   set_bits_r   <= cfg_wdata[3:0];
        REG_WAYS_USED:  ways_r       <= cfg_wdata[3:0];
        REG_BLOCK_BITS: block_bits_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  logic [3:0] ways_eff;
  always_comb begin
    if (ways_r == 4'd0)                   ways_eff = 4'd1;
    else if (int'(ways_r) > MAX_WAYS)     ways_eff = 4'(MAX_WAYS);
    else                                  ways_eff = ways_r;
  end

  // address split of the incoming item
  logic [6:0]       shamt;
  logic [TAG_W-1:0] in_tag;
  logic [63:0]      addr_sh;
  logic [SET_W-1:0] set_mask;
  logic [SET_W-1:0] in_set;

  always_comb begin
    shamt   = 7'(set_bits_r) + 7'(block_bits_r);
    in_tag  = (shamt >= 7'd64) ? '0 : (in_data.addr >> shamt);
    addr_sh = in_data.addr >> block_bits_r;
    if (int'(set_bits_r) >= SET_W) set_mask = '1;
    else                           set_mask = SET_W'((1 << set_bits_r) - 1);
    in_set  = addr_sh[SET_W-1:0] & set_mask;
  end

  // control
  logic             state_r, state_nxt;
  logic [1:0]       op_r;
  logic             second_r;      // second lookup of a modify
  logic             use_cur_r;     // row comes from last write-back, not memory
  logic [TAG_W-1:0] tag_r;
  logic [SET_W-1:0] set_r;
  set_row_t         cur_row_r;

  // set memory with per-row valid flags
  set_row_t            mem [MAX_SETS];
  set_row_t            rd_row_r;
  logic                rd_rv_r;
  logic [MAX_SETS-1:0] row_valid_r;

  set_row_t    row_in, row_new;
  lookup_res_t res;
  logic        fire, last_lk, accept, is_store;

  always_comb begin
    if (use_cur_r)    row_in = cur_row_r;
    else if (rd_rv_r) row_in = rd_row_r;
    else              row_in = '0;
  end

  assign is_store = (op_r == OP_STORE) || second_r;
  assign last_lk  = (op_r != OP_MODIFY) || second_r;
  assign fire     = (state_r == ST_LOOK) && (!out_valid || out_ready);
  assign in_ready = (state_r == ST_IDLE) || (fire && last_lk);
  assign accept   = in_valid && in_ready;

  salru_lookup u_lookup (
    .row_i      (row_in),
    .tag_i      (tag_r),
    .is_store_i (is_store),
    .ways_i     (ways_eff),
    .row_o      (row_new),
    .res_o      (res)
  );

  always_ff @(posedge clk) begin
    if (fire) mem[set_r] <= row_new;
    if (accept) rd_row_r <= mem[in_set];
  end

  always_comb begin
    state_nxt = state_r;
    if (fire && !last_lk)  state_nxt = ST_LOOK;
    else if (accept)       state_nxt = (in_data.op == OP_NONE) ? ST_IDLE : ST_LOOK;
    else if (fire)         state_nxt = ST_IDLE;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      second_r    <= 1'b0;
      use_cur_r   <= 1'b0;
      row_valid_r <= '0;
      rd_rv_r     <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (fire) row_valid_r[set_r] <= 1'b1;
      if (fire && !last_lk) begin
        second_r  <= 1'b1;
        use_cur_r <= 1'b1;
      end else if (accept) begin
        second_r  <= 1'b0;
        // same set as the row being written this edge: forward it
        use_cur_r <= fire && (in_set == set_r);
        rd_rv_r   <= row_valid_r[in_set];
      end else if (fire) begin
        second_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) cur_row_r <= row_new;
    if (accept) begin
      op_r  <= in_data.op;
      tag_r <= in_tag;
      set_r <= in_set;
    end
  end

  // running totals and output register
  logic [CNT_W-1:0] hits_r, misses_r, evicts_r;
  logic [CNT_W-1:0] hits_nxt, misses_nxt, evicts_nxt;
  logic             out_valid_r;
  out_item_t        out_r;

  always_comb begin
    hits_nxt   = (res.hit      && !(&hits_r))   ? hits_r + 1'b1   : hits_r;
    misses_nxt = (res.miss     && !(&misses_r)) ? misses_r + 1'b1 : misses_r;
    evicts_nxt = (res.eviction && !(&evicts_r)) ? evicts_r + 1'b1 : evicts_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hits_r      <= '0;
      misses_r    <= '0;
      evicts_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (fire) begin
        hits_r      <= hits_nxt;
        misses_r    <= misses_nxt;
        evicts_r    <= evicts_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_r.hit             <= res.hit;
      out_r.miss            <= res.miss;
      out_r.eviction        <= res.eviction;
      out_r.last            <= last_lk;
      out_r.hits_total      <= hits_nxt;
      out_r.misses_total    <= misses_nxt;
      out_r.evictions_total <= evicts_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire

/* hdl/salru_lookup.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// salru_lookup
// Hit check, victim choice and age update for one set row.
// ----------------------------------------------------------------------------
module salru_lookup (
  input  var salru_pkg::set_row_t          row_i,
  input  var logic [salru_pkg::TAG_W-1:0]  tag_i,
  input  var logic                         is_store_i,
  input  var logic [3:0]                   ways_i,    // already clamped 1..MAX_WAYS
  output salru_pkg::set_row_t              row_o,
  output salru_pkg::lookup_res_t           res_o
);
  import salru_pkg::*;

  logic [MAX_WAYS-1:0] in_use;
  logic [MAX_WAYS-1:0] hit_vec;
  logic                hit_fnd;
  logic [WAY_W-1:0]    hit_way;
  logic                inv_fnd;
  logic [WAY_W-1:0]    inv_way;
  logic [AGE_W-1:0]    inv_age;
  logic [WAY_W-1:0]    old_way;
  logic [AGE_W-1:0]    old_age;
  logic [WAY_W-1:0]    pick;

  always_comb begin
    hit_fnd = 1'b0;
    hit_way = '0;
    inv_fnd = 1'b0;
    inv_way = '0;
    inv_age = '0;
    old_way = '0;
    old_age = row_i.age[0];
    for (int i = 0; i < MAX_WAYS; i++) begin
      in_use[i]  = (i < int'(ways_i));
      hit_vec[i] = in_use[i] && row_i.valid[i] && (row_i.tag[i] == tag_i);
    end
    for (int i = 0; i < MAX_WAYS; i++) begin
      if (hit_vec[i] && !hit_fnd) begin
        hit_fnd = 1'b1;
        hit_way = WAY_W'(i);
      end
      // load: first invalid; store: oldest invalid, ties to lowest
      if (in_use[i] && !row_i.valid[i]) begin
        if (!inv_fnd || (is_store_i && row_i.age[i] > inv_age)) begin
          inv_fnd = 1'b1;
          inv_way = WAY_W'(i);
          inv_age = row_i.age[i];
        end
      end
      if (i > 0 && in_use[i] && row_i.age[i] > old_age) begin
        old_way = WAY_W'(i);
        old_age = row_i.age[i];
      end
    end

    if (hit_fnd)      pick = hit_way;
    else if (inv_fnd) pick = inv_way;
    else              pick = old_way;

    res_o.hit      = hit_fnd;
    res_o.miss     = !hit_fnd;
    res_o.eviction = !hit_fnd && !inv_fnd;

    row_o = row_i;
    if (!hit_fnd) begin
      row_o.valid[pick] = 1'b1;
      row_o.tag[pick]   = tag_i;
    end
    for (int j = 0; j < MAX_WAYS; j++) begin
      if (in_use[j]) begin
        if (WAY_W'(j) == pick)               row_o.age[j] = '0;
        else if (&row_i.age[j])              row_o.age[j] = row_i.age[j];
        else                                 row_o.age[j] = row_i.age[j] + 1'b1;
      end
    end
  end

endmodule
`default_nettype wire
